>>> hw/rtl/bit_tape_interpreter_top_macros.svh
// Assertion macros for the port-level checker of the bit tape interpreter.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef BIT_TAPE_INTERPRETER_TOP_MACROS_SVH
`define BIT_TAPE_INTERPRETER_TOP_MACROS_SVH

// Same-cycle implication.
`define BTI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bti_pkg.sv
// Shared constants, codes and controller/datapath structs of the bit tape interpreter.
// No dependencies.
package bti_pkg;

    localparam int PROG_DEPTH = 256;
    localparam int TAPE_CELLS = 64;

    localparam int PA_W    = $clog2(PROG_DEPTH);
    localparam int CNT_W   = PA_W + 1;
    localparam int HEAD_W  = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
    localparam int BYTE_W  = 8;
    localparam int TAPE_W  = 64;
    localparam int LEN_W   = 7;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 3;
    localparam int LIMIT_W = 32;
    localparam int STEP_W  = LIMIT_W + 1;
    localparam int LAM_W   = LIMIT_W + 2;
    localparam int REM_CNT_W = $clog2(STEP_W);

    localparam int IN_FIELDS_W = BYTE_W + TAPE_W + LEN_W;
    localparam int IN_W        = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_BYTE_OFF = 0;
    localparam int IN_TAPE_OFF = BYTE_W;
    localparam int IN_LEN_OFF  = BYTE_W + TAPE_W;
    localparam int USER_W      = FUNC_W;

    localparam int OUT_FIELDS_W = TAPE_W + STAT_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD      = OUT_W - OUT_FIELDS_W;
    localparam int OUT_STAT_OFF = TAPE_W;

    localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RUN    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STAT_W-1:0] ST_OPEN_CLS  = 3'd3;
    localparam logic [STAT_W-1:0] ST_OPEN_OPN  = 3'd4;
    localparam logic [STAT_W-1:0] ST_LIMIT     = 3'd5;
    localparam logic [STAT_W-1:0] ST_PROG_LONG = 3'd6;

    localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_FLIP  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

    typedef struct packed {
        logic              load_run;
        logic              append;
        logic              clear;
        logic              prog_rd_i;
        logic              push;
        logic              pop_rd;
        logic              jt_wr_i;
        logic              jt_wr_open;
        logic              i_inc;
        logic              fetch;
        logic              exec;
        logic              det_adv;
        logic              mod_start;
        logic              set_status;
        logic [STAT_W-1:0] status_code;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic overrun;
        logic i_end;
        logic sp_zero;
        logic is_open;
        logic is_close;
        logic is_right;
        logic is_left;
        logic head_last;
        logic head_zero;
        logic pc_end;
        logic det_check;
        logic det_match;
        logic rem_zero;
        logic mod_done;
        logic out_busy;
    } t_stat;

endpackage

>>> hw/rtl/bit_tape_interpreter_top.sv
// Bit tape interpreter top level: stream ports, configuration port, controller and datapath.
// Depends on bti_pkg, bti_ctrl and bti_dpath.
//
// Usage:
//   The input stream carries one command per transaction, selected by s_axis_tuser:
//   append a program byte, clear the program, or run the program on a tape.
//   Append and clear commands may follow back to back.
//   A run returns exactly one output transaction with the final tape and status;
//   append and clear return none. s_axis_tready is low while a run is in progress.
//   A run loads the tape, pairs the brackets of the program, executes its instructions,
//   runs a remainder pass when a repeating state is found, and posts the result.
//   The step limit is written through i_cfg_wr_en / i_cfg_wr_data; the user must write it
//   only while idle, as the block itself does not enforce it.
//   Reset clears the program, the overrun flag, the step limit and the output.
//   If the receiver stalls, the result holds in the output register; the block
//   keeps taking appends and clears, and a following run waits for the slot.
module bit_tape_interpreter_top
    import bti_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [7:0] code_byte, [71:8] tape_bits, [78:72] tape_length, rest zero
    input  logic [IN_W-1:0]    s_axis_tdata,
    // [1:0] func
    input  logic [USER_W-1:0]  s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [63:0] final_tape, [66:64] status, rest zero
    output logic [OUT_W-1:0]   m_axis_tdata,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data
);

    t_cmd  cmd;
    t_stat stat;

    bti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (s_axis_tuser[FUNC_W-1:0]),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    bti_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_code_byte   (s_axis_tdata[IN_BYTE_OFF +: BYTE_W]),
        .i_tape_bits   (s_axis_tdata[IN_TAPE_OFF +: TAPE_W]),
        .i_tape_length (s_axis_tdata[IN_LEN_OFF +: LEN_W]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata)
    );

endmodule

>>> hw/rtl/bti_rem.sv
// Iterative remainder unit: one restoring shift-subtract step per cycle.
// Depends on bti_pkg for the operand widths.
module bti_rem
    import bti_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [STEP_W-1:0]  i_dividend,
    input  logic [LAM_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [STEP_W-1:0]  o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [REM_CNT_W-1:0] r_cnt;
    logic [STEP_W-1:0]    r_quo;
    logic [LAM_W-1:0]     r_div;
    logic [LAM_W-1:0]     r_part;
    logic [LAM_W:0]       trial;
    logic [LAM_W:0]       diff;
    logic [LAM_W-1:0]     n_part;

    assign trial  = {r_part, r_quo[STEP_W-1]};
    assign diff   = trial - {1'b0, r_div};
    assign n_part = (trial >= {1'b0, r_div}) ? diff[LAM_W-1:0] : trial[LAM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == REM_CNT_W'(STEP_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_quo  <= i_dividend;
            r_div  <= i_divisor;
            r_part <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_quo  <= r_quo << 1;
            r_part <= n_part;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_part[STEP_W-1:0];

endmodule

>>> hw/rtl/bti_dpath.sv
// Datapath: program, jump and bracket memories, tape, head, step counting,
// cycle detection and the output register. Depends on bti_pkg and bti_rem.
module bti_dpath
    import bti_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [BYTE_W-1:0]   i_code_byte,
    input  logic [TAPE_W-1:0]   i_tape_bits,
    input  logic [LEN_W-1:0]    i_tape_length,
    input  logic                i_cfg_wr_en,
    input  logic [LIMIT_W-1:0]  i_cfg_wr_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [OUT_W-1:0]    o_out_data
);

    logic [BYTE_W-1:0] r_prog_mem [PROG_DEPTH];
    logic [PA_W-1:0]   r_jt_mem   [PROG_DEPTH];
    logic [PA_W-1:0]   r_stk_mem  [PROG_DEPTH];

    logic [BYTE_W-1:0]  r_prog_rd;
    logic [PA_W-1:0]    r_jt_rd;
    logic [PA_W-1:0]    r_stk_rd;

    logic [CNT_W-1:0]   r_count;
    logic               r_overrun;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    logic [TAPE_W-1:0]  r_tape;
    logic [LEN_W-1:0]   r_len;
    logic [CNT_W-1:0]   r_pc;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_sp;
    logic [HEAD_W-1:0]  r_head;
    logic [STEP_W-1:0]  r_remaining;
    logic [STAT_W-1:0]  r_status;

    logic               r_det_on;
    logic               r_stepped;
    logic [LAM_W-1:0]   r_lam;
    logic [LAM_W-1:0]   r_power;
    logic [CNT_W-1:0]   r_t_pc;
    logic [HEAD_W-1:0]  r_t_head;
    logic [TAPE_W-1:0]  r_t_tape;

    logic               count_full;
    logic               prog_we;
    logic               prog_re;
    logic [PA_W-1:0]    prog_ra;
    logic               jt_we;
    logic [PA_W-1:0]    jt_wa;
    logic [PA_W-1:0]    jt_wd;
    logic [PA_W-1:0]    stk_ra;

    logic [LEN_W-1:0]   len_c;
    logic [TAPE_W-1:0]  len_mask;
    logic [TAPE_W-1:0]  tape_in;
    logic               cur_bit;
    logic               take_jump;
    logic [CNT_W-1:0]   pc_base;
    logic [CNT_W-1:0]   pc_next;
    logic [LAM_W-1:0]   lam_inc;
    logic               rem_done;
    logic [STEP_W-1:0]  rem_val;

    assign count_full = r_count >= CNT_W'(PROG_DEPTH);
    assign prog_we    = i_cmd.append && !count_full;
    assign prog_re    = i_cmd.fetch || i_cmd.prog_rd_i;
    assign prog_ra    = i_cmd.fetch ? r_pc[PA_W-1:0] : r_i[PA_W-1:0];
    assign jt_we      = i_cmd.jt_wr_i || i_cmd.jt_wr_open;
    assign jt_wa      = i_cmd.jt_wr_i ? r_i[PA_W-1:0] : r_stk_rd;
    assign jt_wd      = i_cmd.jt_wr_i ? r_stk_rd : r_i[PA_W-1:0];
    assign stk_ra     = PA_W'(r_sp - 1'b1);

    always_ff @(posedge i_clk) begin
        if (prog_we) begin
            r_prog_mem[r_count[PA_W-1:0]] <= i_code_byte;
        end
        if (prog_re) begin
            r_prog_rd <= r_prog_mem[prog_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (jt_we) begin
            r_jt_mem[jt_wa] <= jt_wd;
        end
        if (i_cmd.fetch) begin
            r_jt_rd <= r_jt_mem[r_pc[PA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stk_mem[r_sp[PA_W-1:0]] <= r_i[PA_W-1:0];
        end
        if (i_cmd.pop_rd) begin
            r_stk_rd <= r_stk_mem[stk_ra];
        end
    end

    always_comb begin
        if (i_tape_length == '0) begin
            len_c = LEN_W'(1);
        end else if (i_tape_length > LEN_W'(TAPE_CELLS)) begin
            len_c = LEN_W'(TAPE_CELLS);
        end else begin
            len_c = i_tape_length;
        end
        for (int k = 0; k < TAPE_W; k++) begin
            len_mask[k] = LEN_W'(k) < len_c;
        end
    end

    assign tape_in = i_tape_bits & len_mask;
    assign cur_bit = r_tape[r_head];

    always_comb begin
        unique case (r_prog_rd)
            CH_OPEN:  take_jump = !cur_bit;
            CH_CLOSE: take_jump = cur_bit;
            default:  take_jump = 1'b0;
        endcase
    end

    assign pc_base = take_jump ? CNT_W'(r_jt_rd) : r_pc;
    assign pc_next = pc_base + 1'b1;
    assign lam_inc = r_lam + 1'b1;

    bti_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (r_remaining),
        .i_divisor  (lam_inc),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_overrun   <= 1'b0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_overrun <= 1'b0;
            end else if (i_cmd.append) begin
                if (count_full) begin
                    r_overrun <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {OUT_PAD'(0), r_status, r_tape};
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.load_run) begin
            r_tape      <= tape_in;
            r_len       <= len_c;
            r_pc        <= '0;
            r_i         <= '0;
            r_sp        <= '0;
            r_head      <= '0;
            r_remaining <= (r_limit == '0) ? (STEP_W'(1) << LIMIT_W) : STEP_W'(r_limit);
            r_det_on    <= 1'b1;
            r_stepped   <= 1'b0;
            r_lam       <= '0;
            r_power     <= LAM_W'(1);
            r_t_pc      <= '0;
            r_t_head    <= '0;
            r_t_tape    <= tape_in;
        end
        if (i_cmd.push) begin
            r_sp <= r_sp + 1'b1;
            r_i  <= r_i + 1'b1;
        end
        if (i_cmd.pop_rd) begin
            r_sp <= r_sp - 1'b1;
        end
        if (i_cmd.i_inc || i_cmd.jt_wr_open) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.det_adv) begin
            r_stepped <= 1'b0;
            if (lam_inc == r_power) begin
                r_t_pc   <= r_pc;
                r_t_head <= r_head;
                r_t_tape <= r_tape;
                r_power  <= r_power << 1;
                r_lam    <= '0;
            end else begin
                r_lam <= lam_inc;
            end
        end
        if (i_cmd.mod_start) begin
            r_det_on  <= 1'b0;
            r_stepped <= 1'b0;
        end
        if (rem_done) begin
            r_remaining <= rem_val;
        end
        if (i_cmd.exec) begin
            r_pc        <= pc_next;
            r_remaining <= r_remaining - 1'b1;
            r_stepped   <= r_det_on;
            unique case (r_prog_rd)
                CH_RIGHT: r_head <= r_head + 1'b1;
                CH_LEFT:  r_head <= r_head - 1'b1;
                CH_FLIP:  r_tape <= r_tape ^ (TAPE_W'(1) << r_head);
                default:  ;
            endcase
        end
    end

    assign o_stat.overrun   = r_overrun;
    assign o_stat.i_end     = r_i >= r_count;
    assign o_stat.sp_zero   = r_sp == '0;
    assign o_stat.is_open   = r_prog_rd == CH_OPEN;
    assign o_stat.is_close  = r_prog_rd == CH_CLOSE;
    assign o_stat.is_right  = r_prog_rd == CH_RIGHT;
    assign o_stat.is_left   = r_prog_rd == CH_LEFT;
    assign o_stat.head_last = (LEN_W'(r_head) + 1'b1) >= r_len;
    assign o_stat.head_zero = r_head == '0;
    assign o_stat.pc_end    = r_pc >= r_count;
    assign o_stat.det_check = r_det_on && r_stepped;
    assign o_stat.det_match = (r_pc == r_t_pc) && (r_head == r_t_head) && (r_tape == r_t_tape);
    assign o_stat.rem_zero  = r_remaining == '0;
    assign o_stat.mod_done  = rem_done;
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> hw/rtl/bti_ctrl.sv
// Controller state machine: program load, bracket pairing, execution sequencing.
// Depends on bti_pkg for the command and status structs.
module bti_ctrl
    import bti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [FUNC_W-1:0] i_func,
    output logic              o_in_ready,
    output t_cmd              o_cmd,
    input  t_stat             i_stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_P_RD  = 4'd1;
    localparam logic [3:0] S_P_DEC = 4'd2;
    localparam logic [3:0] S_P_POP = 4'd3;
    localparam logic [3:0] S_P_JT  = 4'd4;
    localparam logic [3:0] S_FETCH = 4'd5;
    localparam logic [3:0] S_EXEC  = 4'd6;
    localparam logic [3:0] S_MOD   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_func)
                        FN_APPEND: o_cmd.append = 1'b1;
                        FN_CLEAR:  o_cmd.clear  = 1'b1;
                        FN_RUN: begin
                            o_cmd.load_run = 1'b1;
                            if (i_stat.overrun) begin
                                o_cmd.set_status  = 1'b1;
                                o_cmd.status_code = ST_PROG_LONG;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_P_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_P_RD: begin
                if (i_stat.i_end) begin
                    if (i_stat.sp_zero) begin
                        n_state = S_FETCH;
                    end else begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_OPEN_OPN;
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd.prog_rd_i = 1'b1;
                    n_state = S_P_DEC;
                end
            end
            S_P_DEC: begin
                if (i_stat.is_open) begin
                    o_cmd.push = 1'b1;
                    n_state = S_P_RD;
                end else if (i_stat.is_close) begin
                    if (i_stat.sp_zero) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_OPEN_CLS;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.pop_rd = 1'b1;
                        n_state = S_P_POP;
                    end
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state = S_P_RD;
                end
            end
            S_P_POP: begin
                o_cmd.jt_wr_i = 1'b1;
                n_state = S_P_JT;
            end
            S_P_JT: begin
                o_cmd.jt_wr_open = 1'b1;
                n_state = S_P_RD;
            end
            S_FETCH: begin
                if (i_stat.pc_end) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_DONE;
                    n_state = S_DONE;
                end else if (i_stat.det_check && i_stat.det_match) begin
                    o_cmd.mod_start = 1'b1;
                    n_state = S_MOD;
                end else begin
                    o_cmd.det_adv = i_stat.det_check;
                    if (i_stat.rem_zero) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_LIMIT;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.fetch = 1'b1;
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (i_stat.is_right && i_stat.head_last) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_OVERFLOW;
                    n_state = S_DONE;
                end else if (i_stat.is_left && i_stat.head_zero) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_UNDERFLOW;
                    n_state = S_DONE;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_MOD: begin
                if (i_stat.mod_done) begin
                    n_state = S_FETCH;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/bti_chk.sv
// Port-level checker for the bit tape interpreter, bound to the top level.
// Depends on bti_pkg and bit_tape_interpreter_top_macros.svh.
`include "bit_tape_interpreter_top_macros.svh"

module bti_chk
    import bti_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [USER_W-1:0] s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata
);

    `BTI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output transaction dropped while stalled")

    `BTI_ASSERT_NOW(a_status_range, m_axis_tvalid, m_axis_tdata[OUT_STAT_OFF +: STAT_W] <= ST_PROG_LONG, "status code out of range")

    `BTI_ASSERT_NEXT(a_run_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser[FUNC_W-1:0] == FN_RUN, !s_axis_tready, "run transaction did not occupy the block")

    `BTI_ASSERT_NEXT(a_append_fast, s_axis_tvalid && s_axis_tready && s_axis_tuser[FUNC_W-1:0] == FN_APPEND, s_axis_tready, "append transaction stalled the input")

endmodule

bind bit_tape_interpreter_top bti_chk u_chk (.*);

>>> tb/sv/bti_run_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the bit tape interpreter: watches the input, output and step limit ports,
// predicts the final tape and status of every run, and compares them with the results.
// Depends on bti_pkg.
module bti_run_checker
    import bti_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    input  logic               i_s_axis_tready,
    // [7:0] code_byte, [71:8] tape_bits, [78:72] tape_length, rest zero
    input  logic [IN_W-1:0]    i_s_axis_tdata,
    // [1:0] func
    input  logic [USER_W-1:0]  i_s_axis_tuser,
    input  logic               i_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // [63:0] final_tape, [66:64] status, rest zero
    input  logic [OUT_W-1:0]   i_m_axis_tdata,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [TAPE_W-1:0] final_tape;
        logic [STAT_W-1:0] status;
    } t_tape_result;

    logic [BYTE_W-1:0]  prog_mem [PROG_DEPTH];
    int unsigned        prog_len;
    logic               prog_overrun;
    logic [LIMIT_W-1:0] step_limit;
    t_tape_result       expected_results [$];
    int                 fail_total;
    int                 result_index;

    function automatic t_tape_result interpret_run(input logic [TAPE_W-1:0] tape_in,
                                                   input logic [LEN_W-1:0]  len_field);
        int unsigned       cells;
        logic [TAPE_W-1:0] keep;
        logic [TAPE_W-1:0] tape;
        logic [TAPE_W-1:0] saved_tape;
        int unsigned       partner [PROG_DEPTH];
        int unsigned       opens [$];
        int unsigned       pc;
        int unsigned       head;
        int unsigned       saved_pc;
        int unsigned       saved_head;
        int unsigned       j;
        logic [63:0]       budget;
        logic [63:0]       steps;
        logic [63:0]       span;
        logic [63:0]       power;
        logic [63:0]       rem;
        logic [STAT_W-1:0] code;
        logic              cur_bit;
        bit                running;
        bit                tracking;
        t_tape_result      res;

        cells = 32'(len_field);
        if (cells == 0) cells = 1;
        if (cells > TAPE_CELLS) cells = TAPE_CELLS;
        keep = (cells >= TAPE_W) ? '1 : ((64'd1 << cells) - 64'd1);
        tape = tape_in & keep;
        code = ST_DONE;

        if (prog_overrun) begin
            code = ST_PROG_LONG;
        end else begin
            for (int unsigned i = 0; i < prog_len; i++) begin
                if (code == ST_DONE) begin
                    if (prog_mem[i] == CH_OPEN) begin
                        opens.push_back(i);
                    end else if (prog_mem[i] == CH_CLOSE) begin
                        if (opens.size() == 0) begin
                            code = ST_OPEN_CLS;
                        end else begin
                            j = opens.pop_back();
                            partner[j] = i;
                            partner[i] = j;
                        end
                    end
                end
            end
            if (code == ST_DONE && opens.size() != 0) code = ST_OPEN_OPN;
        end

        if (code == ST_DONE) begin
            budget     = (step_limit != 0) ? {32'd0, step_limit} : 64'h1_0000_0000;
            steps      = 0;
            pc         = 0;
            head       = 0;
            tracking   = 1'b1;
            saved_pc   = 0;
            saved_head = 0;
            saved_tape = tape;
            power      = 1;
            span       = 0;
            running    = 1'b1;
            while (running) begin
                if (pc >= prog_len) begin
                    running = 1'b0;
                end else if (steps >= budget) begin
                    code    = ST_LIMIT;
                    running = 1'b0;
                end else begin
                    cur_bit = tape[head];
                    case (prog_mem[pc])
                        CH_RIGHT: begin
                            if (head + 1 >= cells) begin
                                code    = ST_OVERFLOW;
                                running = 1'b0;
                            end else begin
                                head++;
                            end
                        end
                        CH_LEFT: begin
                            if (head == 0) begin
                                code    = ST_UNDERFLOW;
                                running = 1'b0;
                            end else begin
                                head--;
                            end
                        end
                        CH_FLIP: tape[head] = ~tape[head];
                        CH_OPEN: if (!cur_bit) pc = partner[pc];
                        CH_CLOSE: if (cur_bit) pc = partner[pc];
                        default: ;
                    endcase
                    if (running) begin
                        pc++;
                        steps++;
                        // skip the whole laps of a repeating state that fit before the limit
                        if (tracking) begin
                            span++;
                            if (pc == saved_pc && head == saved_head && tape == saved_tape) begin
                                rem      = budget - steps;
                                tracking = 1'b0;
                                steps    = budget - rem % span;
                            end else if (span == power) begin
                                saved_pc   = pc;
                                saved_head = head;
                                saved_tape = tape;
                                power      = power << 1;
                                span       = 0;
                            end
                        end
                    end
                end
            end
        end

        res.final_tape = tape & keep;
        res.status     = code;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_tape_result      want;
        logic [TAPE_W-1:0] got_tape;
        logic [STAT_W-1:0] got_status;
        if (!i_rst_n) begin
            expected_results.delete();
            prog_len     = 0;
            prog_overrun = 1'b0;
            step_limit   = '0;
            fail_total   = 0;
            result_index = 0;
        end else begin
            if (i_cfg_wr_en) step_limit = i_cfg_wr_data;
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                case (i_s_axis_tuser)
                    FN_APPEND: begin
                        if (prog_len < PROG_DEPTH) begin
                            prog_mem[prog_len] = i_s_axis_tdata[IN_BYTE_OFF +: BYTE_W];
                            prog_len++;
                        end else begin
                            prog_overrun = 1'b1;
                        end
                    end
                    FN_CLEAR: begin
                        prog_len     = 0;
                        prog_overrun = 1'b0;
                    end
                    FN_RUN: begin
                        expected_results.push_back(interpret_run(
                            i_s_axis_tdata[IN_TAPE_OFF +: TAPE_W],
                            i_s_axis_tdata[IN_LEN_OFF +: LEN_W]));
                    end
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_tape   = i_m_axis_tdata[TAPE_W-1:0];
                got_status = i_m_axis_tdata[OUT_STAT_OFF +: STAT_W];
                if (expected_results.size() == 0) begin
                    if (fail_total < 10)
                        $display("result %0d with no run pending: tape %h status %0d",
                                 result_index, got_tape, got_status);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (got_tape !== want.final_tape || got_status !== want.status) begin
                        if (fail_total < 10)
                            $display("result %0d: want tape %h status %0d, got %h %0d",
                                     result_index, want.final_tape, want.status,
                                     got_tape, got_status);
                        fail_total++;
                    end
                end
                result_index++;
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
    end

endmodule

>>> tb/sv/bit_tape_interpreter_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the bit tape interpreter: clock, reset, stimulus, stalls and verdict.
// Depends on bti_pkg, bit_tape_interpreter_top and bti_run_checker.
module bit_tape_interpreter_top_tb
    import bti_pkg::*;
();

    localparam logic [FUNC_W-1:0] FN_NOP = 2'd3;
    localparam int ITEM_TARGET   = 1800;
    localparam int QUIET_FROM    = 1550;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 5000000;
    localparam int SHORT_LIMIT   = 600;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata  = '0;
    logic [USER_W-1:0]  s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               i_cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wr_data = '0;

    int fail_count;
    int pending_count;
    int items_sent    = 0;
    int cycle_count   = 0;
    int sink_hold     = 0;
    bit src_idle_on   = 1'b0;
    bit sink_stall_on = 1'b1;

    bit_tape_interpreter_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    bti_run_checker run_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_stall_on && $urandom_range(0, 9) == 0) begin
            sink_hold     <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic put_item(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b,
                            input logic [TAPE_W-1:0] t, input logic [LEN_W-1:0] l);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {{(IN_W - IN_FIELDS_W){1'b0}}, l, t, b};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (f != FN_NOP) items_sent++;
        if (items_sent >= QUIET_FROM) begin
            src_idle_on   = 1'b0;
            sink_stall_on <= 1'b0;
        end
    endtask

    task automatic put_append(input logic [BYTE_W-1:0] c);
        put_item(FN_APPEND, c, {$urandom, $urandom}, LEN_W'($urandom));
    endtask

    task automatic put_clear();
        put_item(FN_CLEAR, BYTE_W'($urandom), {$urandom, $urandom}, LEN_W'($urandom));
    endtask

    task automatic put_nop();
        put_item(FN_NOP, BYTE_W'($urandom), {$urandom, $urandom}, LEN_W'($urandom));
    endtask

    task automatic put_run(input logic [TAPE_W-1:0] t, input logic [LEN_W-1:0] l);
        put_item(FN_RUN, BYTE_W'($urandom), t, l);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) return LEN_W'($urandom_range(0, 127));
        else if (pick < 5) return LEN_W'(TAPE_CELLS);
        else return LEN_W'($urandom_range(1, TAPE_CELLS));
    endfunction

    // Hold off the sender until every run has answered, then let the block settle.
    task automatic wait_quiet();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_step_limit(input logic [LIMIT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Bracket program, balanced unless broken is set; without loop_moves the head never moves inside a loop,
    // which keeps endless loops short enough for large step limits.
    task automatic load_program(input int n, input bit loop_moves, input bit broken);
        logic [BYTE_W-1:0] code [$];
        logic [BYTE_W-1:0] c;
        int                depth;
        int                pick;
        depth = 0;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (depth > 0 && (n - k <= depth || pick < 15)) begin
                c = CH_CLOSE;
            end else if (n - k > depth + 1 && pick < 30) begin
                c = CH_OPEN;
            end else if ((depth == 0 || loop_moves) && pick < 55) begin
                c = CH_RIGHT;
            end else if ((depth == 0 || loop_moves) && pick < 68) begin
                c = CH_LEFT;
            end else if (pick < 94) begin
                c = CH_FLIP;
            end else begin
                c = BYTE_W'($urandom_range(0, 255));
                if (c == CH_RIGHT || c == CH_LEFT || c == CH_FLIP || c == CH_OPEN ||
                    c == CH_CLOSE)
                    c = ~c;
            end
            if (c == CH_OPEN) depth++;
            else if (c == CH_CLOSE) depth--;
            code.push_back(c);
        end
        if (broken && n > 0)
            code[$urandom_range(0, n - 1)] = ($urandom_range(0, 1) != 0) ? CH_OPEN : CH_CLOSE;
        for (int k = 0; k < code.size(); k++) put_append(code[k]);
    endtask

    initial begin : stimulus
        logic [LIMIT_W-1:0] limit;
        bit                 wide;
        bit                 must_clear;
        int                 phase;
        int                 segs;
        int                 kind;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        put_run('1, '0);
        put_append(CH_RIGHT);
        put_run({$urandom, $urandom}, 7'd1);
        put_clear();
        put_append(CH_LEFT);
        put_run({$urandom, $urandom}, 7'd127);
        put_clear();
        put_append(CH_CLOSE);
        put_run({$urandom, $urandom}, pick_length());
        put_clear();
        put_append(CH_OPEN);
        put_run({$urandom, $urandom}, pick_length());
        put_clear();
        put_append(CH_FLIP);
        put_append(CH_OPEN);
        put_append(CH_CLOSE);
        put_run('0, LEN_W'(TAPE_CELLS));
        put_nop();
        wait_quiet();
        write_step_limit('1);
        put_run({$urandom, $urandom}, pick_length());
        wait_quiet();
        write_step_limit(32'd1);
        put_run({$urandom, $urandom}, pick_length());
        put_clear();
        put_append(CH_FLIP);
        put_run({$urandom, $urandom}, pick_length());

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            phase++;
            wait_quiet();
            case ($urandom_range(0, 7))
                0:       limit = '0;
                1:       limit = '1;
                2:       limit = 32'd1;
                3, 4:    limit = $urandom_range(2, 40);
                5, 6:    limit = $urandom_range(41, SHORT_LIMIT);
                default: limit = $urandom | 32'h0001_0000;
            endcase
            write_step_limit(limit);
            wide = (limit == 0) || (limit > SHORT_LIMIT);
            if (items_sent < QUIET_FROM) begin
                src_idle_on   = ($urandom_range(0, 3) != 0);
                sink_stall_on <= ($urandom_range(0, 3) != 0);
            end
            must_clear = 1'b1;
            segs = $urandom_range(2, 5);
            for (int seg = 0; seg < segs; seg++) begin
                kind = $urandom_range(0, 99);
                if (seg == 0 && (phase == 2 || phase == 4)) begin
                    put_clear();
                    load_program((phase == 2) ? PROG_DEPTH : PROG_DEPTH + $urandom_range(1, 4),
                                 !wide, 1'b0);
                    put_run({$urandom, $urandom}, pick_length());
                    put_run({$urandom, $urandom}, pick_length());
                    must_clear = 1'b1;
                end else if (kind < 10) begin
                    repeat ($urandom_range(1, 8)) begin
                        case ($urandom_range(0, 2))
                            0:       put_nop();
                            1:       put_append(BYTE_W'($urandom));
                            default: begin
                                if (!wide) put_run({$urandom, $urandom}, pick_length());
                            end
                        endcase
                    end
                    must_clear = 1'b1;
                end else begin
                    if (must_clear || $urandom_range(0, 3) != 0) put_clear();
                    must_clear = 1'b0;
                    load_program($urandom_range(0, 30), !wide, kind < 25);
                    repeat ($urandom_range(1, 3)) put_run({$urandom, $urandom}, pick_length());
                    if ($urandom_range(0, 7) == 0) wait_quiet();
                end
            end
        end

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
